FILE: src/pcvr_pkg.sv
// Shared types, constants and the CORDIC angle table of the vector register unit.
package pcvr_pkg;

   localparam int FIELD_W     = 32;
   localparam int ANGLE_W     = 32;
   localparam int ANGLE_STEPS = 40;
   localparam int ANGLE_IDX_W = 6;
   localparam int GAIN_W      = 30;
   localparam int CHUNK_W     = 16;
   localparam int ROUND_SHIFT = 30;

   localparam logic [GAIN_W-1:0]  GAIN_Q30         = 30'd652032874;
   localparam logic [ANGLE_W-1:0] HALF_TURN        = 32'h8000_0000;
   localparam logic [ANGLE_W-1:0] QUARTER_TURN     = 32'h4000_0000;
   localparam logic [ANGLE_W-1:0] NEG_QUARTER_TURN = 32'hC000_0000;

   typedef enum logic [1:0] {
      OP_SET_X   = 2'd0,
      OP_SET_Y   = 2'd1,
      OP_SET_DIR = 2'd2,
      OP_SET_MAG = 2'd3
   } opcode_type;

   typedef struct packed {
      logic start;
      logic vectoring;
   } cordic_ctrl_type;

   function automatic logic [ANGLE_W-1:0] atan_angle(input logic [ANGLE_IDX_W-1:0] idx);
      logic [ANGLE_W-1:0] r;
      unique case (idx)
         6'd0:  r = 32'd536870912;
         6'd1:  r = 32'd316933406;
         6'd2:  r = 32'd167458907;
         6'd3:  r = 32'd85004756;
         6'd4:  r = 32'd42667331;
         6'd5:  r = 32'd21354465;
         6'd6:  r = 32'd10680350;
         6'd7:  r = 32'd5340245;
         6'd8:  r = 32'd2670163;
         6'd9:  r = 32'd1335087;
         6'd10: r = 32'd667544;
         6'd11: r = 32'd333772;
         6'd12: r = 32'd166886;
         6'd13: r = 32'd83443;
         6'd14: r = 32'd41722;
         6'd15: r = 32'd20861;
         6'd16: r = 32'd10430;
         6'd17: r = 32'd5215;
         6'd18: r = 32'd2608;
         6'd19: r = 32'd1304;
         6'd20: r = 32'd652;
         6'd21: r = 32'd326;
         6'd22: r = 32'd163;
         6'd23: r = 32'd81;
         6'd24: r = 32'd41;
         6'd25: r = 32'd20;
         6'd26: r = 32'd10;
         6'd27: r = 32'd5;
         6'd28: r = 32'd3;
         6'd29: r = 32'd1;
         6'd30: r = 32'd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

FILE: src/pcvr_if.sv
// Request and response channel interfaces of the vector register unit.
interface pcvr_req_if;
   logic                                   valid;
   logic                                   ready;
   pcvr_pkg::opcode_type                   opcode;
   logic signed [pcvr_pkg::FIELD_W-1:0]    operand_value;

   modport source (output valid, opcode, operand_value, input ready);
   modport sink   (input valid, opcode, operand_value, output ready);
endinterface

interface pcvr_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [pcvr_pkg::FIELD_W-1:0]    x_out;
   logic signed [pcvr_pkg::FIELD_W-1:0]    y_out;
   logic signed [pcvr_pkg::FIELD_W-1:0]    magnitude_out;
   logic signed [pcvr_pkg::FIELD_W-1:0]    direction_out;

   modport source (output valid, x_out, y_out, magnitude_out, direction_out, input ready);
   modport sink   (input valid, x_out, y_out, magnitude_out, direction_out, output ready);
endinterface

FILE: src/pcvr_gain.sv
// Iterative gain correction: rounded product with the CORDIC gain, one chunk a cycle.
module pcvr_gain #(
   parameter int WORK_W = 35
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [WORK_W-1:0] operand,
   output logic signed [WORK_W-1:0] result,
   output logic                     done
);

   localparam int NCHUNK = (WORK_W + pcvr_pkg::CHUNK_W - 1) / pcvr_pkg::CHUNK_W;
   localparam int PAD_W  = NCHUNK * pcvr_pkg::CHUNK_W;
   localparam int ACC_W  = PAD_W + pcvr_pkg::GAIN_W;
   localparam int CNT_W  = $clog2(NCHUNK + 1);
   localparam int PROD_W = pcvr_pkg::CHUNK_W + pcvr_pkg::GAIN_W;
   localparam logic [ACC_W-1:0] ROUND_ADD = ACC_W'(1) << (pcvr_pkg::ROUND_SHIFT - 1);

   logic [PAD_W-1:0]  u_ff, u_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [WORK_W-1:0] abs_val;
   logic [PROD_W-1:0] prod;
   logic [WORK_W-1:0] quot;

   assign abs_val = operand[WORK_W-1] ? WORK_W'(-operand) : WORK_W'(operand);
   assign prod    = u_ff[PAD_W-1 -: pcvr_pkg::CHUNK_W] * pcvr_pkg::GAIN_Q30;
   assign quot    = acc_ff[pcvr_pkg::ROUND_SHIFT +: WORK_W];
   assign result  = neg_ff ? -$signed(quot) : $signed(quot);
   assign done    = done_ff;

   always_comb begin
      u_in    = u_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         u_in    = PAD_W'(abs_val);
         acc_in  = '0;
         cnt_in  = '0;
         neg_in  = operand[WORK_W-1];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == CNT_W'(NCHUNK)) begin
            acc_in  = acc_ff + ROUND_ADD;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            acc_in = (acc_ff << pcvr_pkg::CHUNK_W) + ACC_W'(prod);
            u_in   = u_ff << pcvr_pkg::CHUNK_W;
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      u_ff   <= u_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

endmodule

FILE: src/pcvr_cordic.sv
// Iterative CORDIC unit: one micro-rotation a cycle, vectoring or rotation mode.
module pcvr_cordic #(
   parameter int WORK_W    = 35,
   parameter int NUM_STEPS = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  pcvr_pkg::cordic_ctrl_type        ctrl,
   input  logic signed [WORK_W-1:0]         a_in,
   input  logic signed [WORK_W-1:0]         b_in,
   input  logic [pcvr_pkg::ANGLE_W-1:0]     z_in,
   output logic signed [WORK_W-1:0]         a_out,
   output logic signed [WORK_W-1:0]         b_out,
   output logic [pcvr_pkg::ANGLE_W-1:0]     z_out,
   output logic                             done
);

   localparam int STEP_W = $clog2(NUM_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

   logic signed [WORK_W-1:0]         a_ff, a_in_nx;
   logic signed [WORK_W-1:0]         b_ff, b_in_nx;
   logic [pcvr_pkg::ANGLE_W-1:0]     z_ff, z_in_nx;
   logic [STEP_W-1:0]                step_ff, step_in;
   logic                             vec_ff, vec_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic signed [WORK_W-1:0]         da;
   logic signed [WORK_W-1:0]         db;
   logic [pcvr_pkg::ANGLE_W-1:0]     step_angle;
   logic                             plus;

   assign da         = a_ff >>> step_ff;
   assign db         = b_ff >>> step_ff;
   assign step_angle = pcvr_pkg::atan_angle(pcvr_pkg::ANGLE_IDX_W'(step_ff));
   assign plus       = vec_ff ? !b_ff[WORK_W-1] : z_ff[pcvr_pkg::ANGLE_W-1];
   assign a_out      = a_ff;
   assign b_out      = b_ff;
   assign z_out      = z_ff;
   assign done       = done_ff;

   always_comb begin
      a_in_nx = a_ff;
      b_in_nx = b_ff;
      z_in_nx = z_ff;
      step_in = step_ff;
      vec_in  = vec_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         a_in_nx = a_in;
         b_in_nx = b_in;
         z_in_nx = z_in;
         step_in = '0;
         vec_in  = ctrl.vectoring;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (plus) begin
            a_in_nx = a_ff + db;
            b_in_nx = b_ff - da;
            z_in_nx = z_ff + step_angle;
         end else begin
            a_in_nx = a_ff - db;
            b_in_nx = b_ff + da;
            z_in_nx = z_ff - step_angle;
         end
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff    <= a_in_nx;
      b_ff    <= b_in_nx;
      z_ff    <= z_in_nx;
      step_ff <= step_in;
      vec_ff  <= vec_in;
   end

endmodule

FILE: src/polar_cartesian_vector_register_unit.sv
// Each item runs through the CORDIC loop, one step a cycle, and the chunked gain multiply before
// its response is valid; when x and y are both zero the sequencer skips both. A new item is taken
// only in the idle state, once the previous one has left the sequencer, and the sequencer waits
// in its output state while an earlier response still waits in the output register.
// Synchronous reset clears x, y, magnitude and direction to zero and empties the output.
module polar_cartesian_vector_register_unit #(
   parameter int DATA_WIDTH   = 32,
   parameter int CORDIC_STEPS = 24
) (
   input  logic          clock,
   input  logic          reset,
   pcvr_req_if.sink      req_chan,
   pcvr_rsp_if.source    rsp_chan
);

   localparam int FW = pcvr_pkg::FIELD_W;
   localparam int AW = pcvr_pkg::ANGLE_W;
   localparam int W  = DATA_WIDTH + 3;
   localparam int NUM_STEPS = (CORDIC_STEPS < pcvr_pkg::ANGLE_STEPS) ?
                              CORDIC_STEPS : pcvr_pkg::ANGLE_STEPS;
   localparam logic signed [DATA_WIDTH-1:0] DW_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] DW_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP_POLAR,
      ST_VECTOR,
      ST_GAIN_POLAR,
      ST_PREP_RECT,
      ST_GAIN_RECT,
      ST_ROTATE,
      ST_OUTPUT
   } state_type;

   function automatic logic signed [DATA_WIDTH-1:0] sat(input logic signed [W-1:0] v);
      logic signed [DATA_WIDTH-1:0] r;
      if (v > W'(DW_MAX)) begin
         r = DW_MAX;
      end else if (v < W'(DW_MIN)) begin
         r = DW_MIN;
      end else begin
         r = DATA_WIDTH'(v);
      end
      return r;
   endfunction

   state_type                     state_ff, state_in;
   logic signed [DATA_WIDTH-1:0]  x_ff, x_in;
   logic signed [DATA_WIDTH-1:0]  y_ff, y_in;
   logic signed [DATA_WIDTH-1:0]  mag_ff, mag_in;
   logic [AW-1:0]                 dir_ff, dir_in;
   logic [AW-1:0]                 z_start_ff, z_start_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [FW-1:0]          rsp_x_ff, rsp_x_in;
   logic signed [FW-1:0]          rsp_y_ff, rsp_y_in;
   logic signed [FW-1:0]          rsp_mag_ff, rsp_mag_in;
   logic signed [FW-1:0]          rsp_dir_ff, rsp_dir_in;

   pcvr_pkg::cordic_ctrl_type     cordic_ctrl;
   logic signed [W-1:0]           cordic_a, cordic_b;
   logic [AW-1:0]                 cordic_z;
   logic signed [W-1:0]           cordic_a_out, cordic_b_out;
   logic [AW-1:0]                 cordic_z_out;
   logic                          cordic_done;
   logic                          gain_start;
   logic signed [W-1:0]           gain_operand;
   logic signed [W-1:0]           gain_result;
   logic                          gain_done;

   logic signed [W-1:0]           x_ext, y_ext, mag_ext;
   logic                          zero_vec;
   logic                          y_neg;
   logic                          wrap_dir;
   logic                          out_free;

   assign x_ext    = W'(x_ff);
   assign y_ext    = W'(y_ff);
   assign mag_ext  = W'(mag_ff);
   assign zero_vec = (x_ff == '0) && (y_ff == '0);
   assign y_neg    = y_ff[DATA_WIDTH-1];
   assign wrap_dir = ($signed(dir_ff) > $signed(pcvr_pkg::QUARTER_TURN)) ||
                     ($signed(dir_ff) < $signed(pcvr_pkg::NEG_QUARTER_TURN));
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign cordic_ctrl.vectoring = (state_ff == ST_PREP_POLAR);
   assign cordic_ctrl.start     = ((state_ff == ST_PREP_POLAR) && !zero_vec) ||
                                  ((state_ff == ST_GAIN_RECT) && gain_done);
   assign cordic_a = cordic_ctrl.vectoring ? (y_neg ? -y_ext : y_ext) : gain_result;
   assign cordic_b = cordic_ctrl.vectoring ? (y_neg ? -x_ext : x_ext) : '0;
   assign cordic_z = cordic_ctrl.vectoring ? (y_neg ? pcvr_pkg::HALF_TURN : '0) : z_start_ff;

   assign gain_start   = ((state_ff == ST_VECTOR) && cordic_done) || (state_ff == ST_PREP_RECT);
   assign gain_operand = (state_ff == ST_PREP_RECT) ? (wrap_dir ? -mag_ext : mag_ext)
                                                    : cordic_a_out;

   pcvr_cordic #(
      .WORK_W    (W),
      .NUM_STEPS (NUM_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .ctrl  (cordic_ctrl),
      .a_in  (cordic_a),
      .b_in  (cordic_b),
      .z_in  (cordic_z),
      .a_out (cordic_a_out),
      .b_out (cordic_b_out),
      .z_out (cordic_z_out),
      .done  (cordic_done)
   );

   pcvr_gain #(
      .WORK_W (W)
   ) u_gain (
      .clock   (clock),
      .reset   (reset),
      .start   (gain_start),
      .operand (gain_operand),
      .result  (gain_result),
      .done    (gain_done)
   );

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.x_out         = rsp_x_ff;
   assign rsp_chan.y_out         = rsp_y_ff;
   assign rsp_chan.magnitude_out = rsp_mag_ff;
   assign rsp_chan.direction_out = rsp_dir_ff;

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      mag_in       = mag_ff;
      dir_in       = dir_ff;
      z_start_in   = z_start_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_mag_in   = rsp_mag_ff;
      rsp_dir_in   = rsp_dir_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               unique case (req_chan.opcode)
                  pcvr_pkg::OP_SET_X: begin
                     x_in     = DATA_WIDTH'(req_chan.operand_value);
                     state_in = ST_PREP_POLAR;
                  end
                  pcvr_pkg::OP_SET_Y: begin
                     y_in     = DATA_WIDTH'(req_chan.operand_value);
                     state_in = ST_PREP_POLAR;
                  end
                  pcvr_pkg::OP_SET_DIR: begin
                     dir_in   = AW'(req_chan.operand_value);
                     state_in = ST_PREP_RECT;
                  end
                  pcvr_pkg::OP_SET_MAG: begin
                     mag_in   = DATA_WIDTH'(req_chan.operand_value);
                     state_in = ST_PREP_RECT;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_PREP_POLAR: begin
            if (zero_vec) begin
               mag_in   = '0;
               dir_in   = '0;
               state_in = ST_OUTPUT;
            end else begin
               state_in = ST_VECTOR;
            end
         end
         ST_VECTOR: begin
            if (cordic_done) begin
               state_in = ST_GAIN_POLAR;
            end
         end
         ST_GAIN_POLAR: begin
            if (gain_done) begin
               mag_in   = sat(gain_result);
               dir_in   = cordic_z_out;
               state_in = ST_OUTPUT;
            end
         end
         ST_PREP_RECT: begin
            z_start_in = wrap_dir ? (dir_ff - pcvr_pkg::HALF_TURN) : dir_ff;
            state_in   = ST_GAIN_RECT;
         end
         ST_GAIN_RECT: begin
            if (gain_done) begin
               state_in = ST_ROTATE;
            end
         end
         ST_ROTATE: begin
            if (cordic_done) begin
               y_in     = sat(cordic_a_out);
               x_in     = sat(cordic_b_out);
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = FW'(x_ff);
               rsp_y_in     = FW'(y_ff);
               rsp_mag_in   = FW'(mag_ff);
               rsp_dir_in   = FW'(dir_ff);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         x_ff         <= '0;
         y_ff         <= '0;
         mag_ff       <= '0;
         dir_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         mag_ff       <= mag_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      z_start_ff <= z_start_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_mag_ff <= rsp_mag_in;
      rsp_dir_ff <= rsp_dir_in;
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("unit ready right after taking an item");

   a_cordic_done_state: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> (state_ff == ST_VECTOR || state_ff == ST_ROTATE))
      else $error("CORDIC finished outside a CORDIC state");

   a_gain_done_state: assert property (@(posedge clock) disable iff (reset)
      gain_done |-> (state_ff == ST_GAIN_POLAR || state_ff == ST_GAIN_RECT))
      else $error("gain unit finished outside a gain state");

   a_output_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUTPUT && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not presented after leaving the output state");

endmodule

FILE: bench/tb_polar_cartesian_vector_register_unit.sv
// Self-checking testbench of the polar/Cartesian vector register unit with a CORDIC-exact predictor.
module tb_polar_cartesian_vector_register_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int      ROTATION_STEPS = 24;
   localparam int      RANDOM_ITEMS   = 930;
   localparam int      CYCLE_LIMIT    = 400000;
   localparam int      SETTLE_CYCLES  = 64;
   localparam longint  FIELD_MAX      = 64'sd2147483647;
   localparam longint  FIELD_MIN      = -64'sd2147483648;

   localparam logic [pcvr_pkg::ANGLE_W-1:0] ARC_STEP [0:ROTATION_STEPS-1] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10680350,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
      32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef struct {
      pcvr_pkg::opcode_type         op;
      logic [pcvr_pkg::FIELD_W-1:0] value;
      bit                           drain;
   } update_item_type;

   typedef struct packed {
      logic [pcvr_pkg::FIELD_W-1:0] x;
      logic [pcvr_pkg::FIELD_W-1:0] y;
      logic [pcvr_pkg::FIELD_W-1:0] mag;
      logic [pcvr_pkg::FIELD_W-1:0] dir;
   } vector_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pcvr_req_if req_chan ();
   pcvr_rsp_if rsp_chan ();

   polar_cartesian_vector_register_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   longint                       vec_x = 0;
   longint                       vec_y = 0;
   longint                       vec_mag = 0;
   logic [pcvr_pkg::ANGLE_W-1:0] vec_dir = '0;

   update_item_type  send_q[$];
   vector_state_type expected_vectors[$];
   int               pending_results = 0;
   bit               quiet_tail = 1'b0;
   int               mismatch_count = 0;
   int               sent_count = 0;
   int               received_count = 0;
   int               sender_gap = 0;
   int               stall_left = 0;
   int               cycle_count = 0;

   function automatic longint gain_scale(longint v);
      longint unsigned mag_u, hi, lo, sum;
      mag_u = (v < 0) ? longint'(-v) : longint'(v);
      hi    = (mag_u >> 25) * pcvr_pkg::GAIN_Q30;
      lo    = (mag_u & 64'h1FF_FFFF) * pcvr_pkg::GAIN_Q30;
      sum   = (hi >> 5) + ((((hi & 64'd31) << 25) + lo + (64'd1 << 29)) >> 30);
      return (v < 0) ? -longint'(sum) : longint'(sum);
   endfunction

   function automatic longint clamp_field(longint v);
      if (v > FIELD_MAX) return FIELD_MAX;
      if (v < FIELD_MIN) return FIELD_MIN;
      return v;
   endfunction

   function automatic void vector_to_polar();
      longint                       a, b, da, db;
      logic [pcvr_pkg::ANGLE_W-1:0] z;
      int                           i;
      if (vec_x == 0 && vec_y == 0) begin
         vec_mag = 0;
         vec_dir = '0;
         return;
      end
      a = vec_y;
      b = vec_x;
      z = '0;
      if (a < 0) begin
         a = -a;
         b = -b;
         z = pcvr_pkg::HALF_TURN;
      end
      for (i = 0; i < ROTATION_STEPS; i++) begin
         da = a >>> i;
         db = b >>> i;
         if (b >= 0) begin
            a = a + db;
            b = b - da;
            z = z + ARC_STEP[i];
         end else begin
            a = a - db;
            b = b + da;
            z = z - ARC_STEP[i];
         end
      end
      vec_mag = clamp_field(gain_scale(a));
      vec_dir = z;
   endfunction

   function automatic void polar_to_vector();
      longint                       m, a, b, da, db;
      logic [pcvr_pkg::ANGLE_W-1:0] z;
      int                           i;
      m = vec_mag;
      z = vec_dir;
      if ($signed(z) > $signed(pcvr_pkg::QUARTER_TURN) ||
          $signed(z) < $signed(pcvr_pkg::NEG_QUARTER_TURN)) begin
         m = -m;
         z = z - pcvr_pkg::HALF_TURN;
      end
      a = gain_scale(m);
      b = 0;
      for (i = 0; i < ROTATION_STEPS; i++) begin
         da = a >>> i;
         db = b >>> i;
         if (!z[pcvr_pkg::ANGLE_W-1]) begin
            a = a - db;
            b = b + da;
            z = z - ARC_STEP[i];
         end else begin
            a = a + db;
            b = b - da;
            z = z + ARC_STEP[i];
         end
      end
      vec_y = clamp_field(a);
      vec_x = clamp_field(b);
   endfunction

   function automatic vector_state_type apply_update(pcvr_pkg::opcode_type op,
                                                     logic [pcvr_pkg::FIELD_W-1:0] value);
      vector_state_type r;
      case (op)
         pcvr_pkg::OP_SET_X: begin
            vec_x = longint'($signed(value));
            vector_to_polar();
         end
         pcvr_pkg::OP_SET_Y: begin
            vec_y = longint'($signed(value));
            vector_to_polar();
         end
         pcvr_pkg::OP_SET_DIR: begin
            vec_dir = value;
            polar_to_vector();
         end
         default: begin
            vec_mag = longint'($signed(value));
            polar_to_vector();
         end
      endcase
      r.x   = vec_x[pcvr_pkg::FIELD_W-1:0];
      r.y   = vec_y[pcvr_pkg::FIELD_W-1:0];
      r.mag = vec_mag[pcvr_pkg::FIELD_W-1:0];
      r.dir = vec_dir;
      return r;
   endfunction

   function automatic logic [pcvr_pkg::FIELD_W-1:0] random_operand();
      logic [pcvr_pkg::FIELD_W-1:0] r;
      r = $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return r;
         4, 5:       return {{11{r[20]}}, r[20:0]};
         6: begin
            case ($urandom_range(0, 4))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'h0000_0000;
               3:       return 32'h0000_0001;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default:    return {{7{r[24]}}, r[24:0]};
      endcase
   endfunction

   task automatic queue_item(pcvr_pkg::opcode_type op, logic [pcvr_pkg::FIELD_W-1:0] value,
                             bit drain);
      update_item_type it;
      it.op    = op;
      it.value = value;
      it.drain = drain;
      send_q.push_back(it);
   endtask

   task automatic note_mismatch(string field, logic [pcvr_pkg::FIELD_W-1:0] want,
                                logic [pcvr_pkg::FIELD_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch on %s: expected %h, got %h", field, want, got);
   endtask

   always @(posedge clock) begin
      bit present;
      present = 1'b0;
      if (reset) begin
         req_chan.valid <= 1'b0;
         sender_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            void'(send_q.pop_front());
            sent_count++;
         end
         if (req_chan.valid && !req_chan.ready)
            present = 1'b1;
         else if (sender_gap > 0)
            sender_gap--;
         else if (send_q.size() == 0)
            present = 1'b0;
         else if (send_q[0].drain && (req_chan.valid || pending_results != 0))
            present = 1'b0;
         else if (!quiet_tail && ((sent_count / 100) % 3) != 2
                  && $urandom_range(0, 4) == 0)
            sender_gap = $urandom_range(1, 6) - 1;
         else
            present = 1'b1;
         req_chan.valid <= present;
         if (present) begin
            req_chan.opcode        <= send_q[0].op;
            req_chan.operand_value <= send_q[0].value;
         end
         quiet_tail <= (send_q.size() < 100);
      end
   end

   always @(posedge clock) begin
      vector_state_type want, got;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            received_count++;
            got.x   = rsp_chan.x_out;
            got.y   = rsp_chan.y_out;
            got.mag = rsp_chan.magnitude_out;
            got.dir = rsp_chan.direction_out;
            if (expected_vectors.size() == 0) begin
               note_mismatch("response with nothing pending", '0, got.x);
            end else begin
               want = expected_vectors.pop_front();
               if (got.x !== want.x)     note_mismatch("x_out", want.x, got.x);
               if (got.y !== want.y)     note_mismatch("y_out", want.y, got.y);
               if (got.mag !== want.mag) note_mismatch("magnitude_out", want.mag, got.mag);
               if (got.dir !== want.dir) note_mismatch("direction_out", want.dir, got.dir);
            end
         end
         if (req_chan.valid && req_chan.ready)
            expected_vectors.push_back(apply_update(req_chan.opcode, req_chan.operand_value));
         pending_results <= expected_vectors.size();
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!quiet_tail && ((received_count / 90) % 3) != 1
                      && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL polar_cartesian_vector_register_unit");
         $finish;
      end
   end

   initial begin
      int n;
      req_chan.valid         = 1'b0;
      req_chan.opcode        = pcvr_pkg::OP_SET_X;
      req_chan.operand_value = '0;
      rsp_chan.ready         = 1'b0;

      queue_item(pcvr_pkg::OP_SET_X,   32'h0000_0000, 1'b0);
      queue_item(pcvr_pkg::OP_SET_Y,   32'h0000_0000, 1'b0);
      queue_item(pcvr_pkg::OP_SET_X,   32'h0000_0001, 1'b0);
      queue_item(pcvr_pkg::OP_SET_X,   32'hFFFF_FFFF, 1'b0);
      queue_item(pcvr_pkg::OP_SET_X,   32'h7FFF_FFFF, 1'b0);
      queue_item(pcvr_pkg::OP_SET_Y,   32'h7FFF_FFFF, 1'b0);
      queue_item(pcvr_pkg::OP_SET_Y,   32'h8000_0000, 1'b0);
      queue_item(pcvr_pkg::OP_SET_X,   32'h8000_0000, 1'b0);
      queue_item(pcvr_pkg::OP_SET_Y,   32'hFFFE_0000, 1'b0);
      queue_item(pcvr_pkg::OP_SET_X,   32'h0000_0000, 1'b1);
      queue_item(pcvr_pkg::OP_SET_MAG, 32'h0001_0000, 1'b0);
      queue_item(pcvr_pkg::OP_SET_DIR, 32'h0000_0000, 1'b0);
      queue_item(pcvr_pkg::OP_SET_DIR, pcvr_pkg::QUARTER_TURN, 1'b0);
      queue_item(pcvr_pkg::OP_SET_DIR, 32'h4000_0001, 1'b0);
      queue_item(pcvr_pkg::OP_SET_DIR, pcvr_pkg::HALF_TURN, 1'b0);
      queue_item(pcvr_pkg::OP_SET_DIR, pcvr_pkg::NEG_QUARTER_TURN, 1'b0);
      queue_item(pcvr_pkg::OP_SET_DIR, 32'hBFFF_FFFF, 1'b0);
      queue_item(pcvr_pkg::OP_SET_DIR, 32'hFFFF_FFFF, 1'b0);
      queue_item(pcvr_pkg::OP_SET_DIR, 32'h0000_0000, 1'b0);
      queue_item(pcvr_pkg::OP_SET_MAG, 32'h7FFF_FFFF, 1'b0);
      queue_item(pcvr_pkg::OP_SET_MAG, 32'hFFFF_0000, 1'b0);
      queue_item(pcvr_pkg::OP_SET_MAG, 32'h8000_0000, 1'b0);
      queue_item(pcvr_pkg::OP_SET_DIR, 32'h2000_0000, 1'b0);
      queue_item(pcvr_pkg::OP_SET_MAG, 32'h0000_0000, 1'b0);
      queue_item(pcvr_pkg::OP_SET_MAG, 32'h0000_0001, 1'b0);
      for (n = 0; n < RANDOM_ITEMS; n++)
         queue_item(pcvr_pkg::opcode_type'($urandom_range(0, 3)), random_operand(),
                    (n % 150) == 0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (send_q.size() != 0 || req_chan.valid || pending_results != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_vectors.size() != 0)
         $display("%0d expected responses never arrived", expected_vectors.size());
      if (mismatch_count == 0 && expected_vectors.size() == 0) begin
         $display("PASS polar_cartesian_vector_register_unit");
      end else begin
         $display("FAIL polar_cartesian_vector_register_unit");
      end
      $finish;
   end

endmodule
